// File: rtl/core/ccbmm_pkg.sv
// shared types and constants of the cpu bus memory map unit
`timescale 1ns / 1ps

package ccbmm_pkg;

  // bus operation codes
  localparam logic [2:0] OP_RD_BYTE = 3'd0;
  localparam logic [2:0] OP_WR_BYTE = 3'd1;
  localparam logic [2:0] OP_RD_WORD = 3'd2;
  localparam logic [2:0] OP_WR_WORD = 3'd3;
  localparam logic [2:0] OP_RD_PAGE = 3'd4;
  localparam logic [2:0] OP_WR_PAGE = 3'd5;

  // field widths
  localparam int OP_W   = 3;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 16;

  // ram window is the bottom 8 KB of the bus
  localparam int RAM_WIN_W = 13;

  // byte returned by every unmapped address
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  // default work ram depth in bytes
  localparam int RAM_DEPTH_DEF = 2048;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted transfer
    logic mem_en;    // perform one ram byte access
    logic sel_hi;    // access the high byte address
    logic lat_lo;    // hold the low byte of a word read
    logic res_load;  // load the output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic legal;  // opcode is a defined operation
    logic word;   // two byte operation
    logic write;  // store operation
  } dp_status_t;

endpackage

// File: rtl/core/ccbmm_ctrl.sv
// controller state machine that sequences ram byte accesses and the result
`timescale 1ns / 1ps

module ccbmm_ctrl
  import ccbmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LO   = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       res_free;

  // the output register can take a new result
  assign res_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LO;
        end
      end
      ST_LO: begin
        if (!status_i.legal) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.mem_en = 1'b1;
          if (status_i.word) begin
            state_d = ST_HI;
          end else if (status_i.write) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_HI: begin
        cmd_o.mem_en = 1'b1;
        cmd_o.sel_hi = 1'b1;
        cmd_o.lat_lo = !status_i.write;
        state_d      = status_i.write ? ST_IDLE : ST_FIN;
      end
      ST_FIN: begin
        if (res_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid: set on a new result, cleared by a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/ccbmm_datapath.sv
// datapath: operation registers, address decode, work ram and result register
`timescale 1ns / 1ps

module ccbmm_datapath
  import ccbmm_pkg::*;
#(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic              clk_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ADDR_W-1:0] access_address_i,
  input  logic [DATA_W-1:0] write_data_i,
  output logic [DATA_W-1:0] read_data_o
);

  localparam int IDX_W     = $clog2(RAM_DEPTH);
  // compare and subtract steps that bring a window address below the depth
  localparam int RED_STEPS = RAM_WIN_W - IDX_W + 1;
  localparam int WIDE_W    = RAM_WIN_W + RED_STEPS;

  logic [OP_W-1:0]      op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [DATA_W-1:0]    wdata_q;
  logic [ADDR_W-1:0]    hi_addr;
  logic [ADDR_W-1:0]    eff_addr;
  logic                 mapped;
  logic                 paged;
  logic [RAM_WIN_W-1:0] win_rem;
  logic [IDX_W-1:0]     ram_idx;
  logic [7:0]           wr_byte;
  logic [7:0]           ram [RAM_DEPTH];
  logic [7:0]           rdata_q;
  logic                 map_q;
  logic [7:0]           rd_byte;
  logic [7:0]           lo_q;
  logic [DATA_W-1:0]    res_q;

  // operation decode
  assign status_o.legal = op_q inside {OP_RD_BYTE, OP_WR_BYTE, OP_RD_WORD,
                                       OP_WR_WORD, OP_RD_PAGE, OP_WR_PAGE};
  assign status_o.word  = op_q inside {OP_RD_WORD, OP_WR_WORD, OP_RD_PAGE, OP_WR_PAGE};
  assign status_o.write = op_q inside {OP_WR_BYTE, OP_WR_WORD, OP_WR_PAGE};
  assign paged          = op_q inside {OP_RD_PAGE, OP_WR_PAGE};

  // high byte address: wraps at 16 bits, or within the page
  assign hi_addr = paged ? {addr_q[15:8], addr_q[7:0] + 8'd1} : addr_q + 16'd1;
  assign eff_addr = cmd_i.sel_hi ? hi_addr : addr_q;
  assign mapped   = (eff_addr[ADDR_W-1:RAM_WIN_W] == '0);

  // ram mirroring: window address modulo the depth
  always_comb begin
    win_rem = eff_addr[RAM_WIN_W-1:0];
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (WIDE_W'(win_rem) >= (WIDE_W'(RAM_DEPTH) << k)) begin
        win_rem = win_rem - RAM_WIN_W'(WIDE_W'(RAM_DEPTH) << k);
      end
    end
  end
  assign ram_idx = win_rem[IDX_W-1:0];

  assign wr_byte = cmd_i.sel_hi ? wdata_q[15:8] : wdata_q[7:0];

  // work ram, one byte access a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_en && mapped) begin
      if (status_o.write) begin
        ram[ram_idx] <= wr_byte;
      end else begin
        rdata_q <= ram[ram_idx];
      end
    end
  end

  assign rd_byte = map_q ? rdata_q : UNMAPPED_BYTE;

  // operation, byte and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      addr_q  <= access_address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.mem_en) begin
      map_q <= mapped;
    end
    if (cmd_i.lat_lo) begin
      lo_q <= rd_byte;
    end
    if (cmd_i.res_load) begin
      res_q <= status_o.word ? {rd_byte, lo_q} : {8'h00, rd_byte};
    end
  end

  assign read_data_o = res_q;

endmodule

// File: rtl/core/console_cpu_bus_memory_map_unit.sv
// top level of the console cpu bus memory map unit
`timescale 1ns / 1ps

// CPU bus memory map with a single-port work RAM of RAM_DEPTH bytes that
// repeats across bus addresses 0x0000-0x1FFF; every other address reads 0xFF
// and ignores writes. One operation is taken at a time: a byte write or unused
// opcode passes through state ST_LO only, a byte read ST_LO and ST_FIN, a word
// write ST_LO and ST_HI, and a word read ST_LO, ST_HI and ST_FIN before the
// next transfer is taken; the single RAM port, one byte per cycle, and its
// registered read data set these steps. Results wait in an output register, so
// a new operation is taken while an earlier result is still stalled. The RAM
// holds no reset value and needs no clearing pass: reading a byte that was
// never written returns unspecified data. Writes return no result.
module console_cpu_bus_memory_map_unit
  import ccbmm_pkg::*;
#(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ADDR_W-1:0] access_address_i,
  input  logic [DATA_W-1:0] write_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] read_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  ccbmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  ccbmm_datapath #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .access_address_i (access_address_i),
    .write_data_i     (write_data_i),
    .read_data_o      (read_data_o)
  );

  // a result never overwrites one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // a write transfer does not produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (opcode_i == OP_WR_BYTE || opcode_i == OP_WR_WORD || opcode_i == OP_WR_PAGE))
    |=> !cmd.res_load ##1 !cmd.res_load ##1 !cmd.res_load)
    else $error("write transfer produced a result");

  // output valid only rises from a result load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.res_load))
    else $error("output valid without a result load");

endmodule

// File: tb/sv/tb_console_cpu_bus_memory_map_unit.sv
// self-checking testbench of the console cpu bus memory map unit
`timescale 1ns / 1ps

module tb_console_cpu_bus_memory_map_unit;
  import ccbmm_pkg::*;

  // opcodes the unit must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int RANDOM_ITEMS   = 510;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [ADDR_W-1:0] access_address_i;
  logic [DATA_W-1:0] write_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] read_data_o;

  // idle and stall rates in percent
  int send_idle_pct;
  int recv_stall_pct;

  // shadow of the work ram and the set of bytes written so far
  logic [7:0]  shadow_ram [RAM_DEPTH_DEF];
  bit          shadow_written [RAM_DEPTH_DEF];
  int          written_idx_q [$];

  // read data still owed by the unit, oldest first
  logic [DATA_W-1:0] pending_read_q [$];
  int                mismatch_cnt;

  console_cpu_bus_memory_map_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .access_address_i (access_address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("console_cpu_bus_memory_map_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit in_ram_window(logic [ADDR_W-1:0] addr);
    return addr[ADDR_W-1:RAM_WIN_W] == '0;
  endfunction

  // address of the high byte of a word access
  function automatic logic [ADDR_W-1:0] high_byte_address(logic [OP_W-1:0] op,
                                                          logic [ADDR_W-1:0] addr);
    if (op == OP_RD_PAGE || op == OP_WR_PAGE) begin
      return {addr[15:8], addr[7:0] + 8'd1};
    end
    return addr + 16'd1;
  endfunction

  function automatic logic [7:0] bus_fetch(logic [ADDR_W-1:0] addr);
    if (in_ram_window(addr)) return shadow_ram[addr % RAM_DEPTH_DEF];
    return UNMAPPED_BYTE;
  endfunction

  function automatic void bus_store(logic [ADDR_W-1:0] addr, logic [7:0] value);
    int idx;
    if (in_ram_window(addr)) begin
      idx = addr % RAM_DEPTH_DEF;
      shadow_ram[idx] = value;
      if (!shadow_written[idx]) begin
        shadow_written[idx] = 1'b1;
        written_idx_q.push_back(idx);
      end
    end
  endfunction

  // true when no byte touched by the read is unwritten ram
  function automatic bit read_is_defined(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] hi;
    bit ok;
    ok = !in_ram_window(addr) || shadow_written[addr % RAM_DEPTH_DEF];
    if (op == OP_RD_WORD || op == OP_RD_PAGE) begin
      hi = high_byte_address(op, addr);
      ok = ok && (!in_ram_window(hi) || shadow_written[hi % RAM_DEPTH_DEF]);
    end
    return ok;
  endfunction

  // update the shadow memory and queue the read data for one accepted transfer
  function automatic void predict_bus_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                         logic [DATA_W-1:0] data);
    logic [ADDR_W-1:0] hi;
    hi = high_byte_address(op, addr);
    case (op)
      OP_RD_BYTE: pending_read_q.push_back({8'h00, bus_fetch(addr)});
      OP_WR_BYTE: bus_store(addr, data[7:0]);
      OP_RD_WORD, OP_RD_PAGE: pending_read_q.push_back({bus_fetch(hi), bus_fetch(addr)});
      OP_WR_WORD, OP_WR_PAGE: begin
        bus_store(addr, data[7:0]);
        bus_store(hi, data[15:8]);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  // one bus operation, starting and ending at a falling edge
  task automatic send_bus_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    opcode_i         = op;
    access_address_i = addr;
    write_data_i     = data;
    do @(posedge clk_i); while (in_stall_o);
    predict_bus_op(op, addr, data);
    @(negedge clk_i);
  endtask

  // receiver stall pattern
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = $urandom_range(99) < recv_stall_pct;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string what, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: read_data expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // compare each result transfer with the oldest owed read
  always @(posedge clk_i) begin : check_results
    logic [DATA_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_read_q.size() == 0) begin
        note_mismatch("result with no read pending", 'x, read_data_o);
      end else begin
        want = pending_read_q.pop_front();
        if (read_data_o !== want) note_mismatch("wrong read data", want, read_data_o);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // byte access at the ends of the ram window and of the bus
  task automatic test_byte_extremes();
    send_bus_op(OP_WR_BYTE, 16'h0000, 16'hFFFF);
    send_bus_op(OP_RD_BYTE, 16'h0000, 16'h0000);
    send_bus_op(OP_WR_BYTE, 16'h1FFF, 16'h0000);
    send_bus_op(OP_RD_BYTE, 16'h07FF, 16'hFFFF);
    send_bus_op(OP_RD_BYTE, 16'hFFFF, 16'h0000);
  endtask

  // plain word access crossing the ram size, the window end and the bus end
  task automatic test_word_wrap();
    send_bus_op(OP_WR_WORD, 16'h07FF, 16'hA55A);
    send_bus_op(OP_RD_WORD, 16'h17FF, 16'h0000);
    send_bus_op(OP_RD_WORD, 16'hFFFF, 16'h0000);
    send_bus_op(OP_WR_WORD, 16'h1FFF, 16'h1234);
    send_bus_op(OP_RD_WORD, 16'h1FFF, 16'h0000);
  endtask

  // paged word access wrapping inside its page
  task automatic test_page_wrap();
    send_bus_op(OP_WR_PAGE, 16'h03FF, 16'hBEEF);
    send_bus_op(OP_RD_PAGE, 16'h03FF, 16'h0000);
    send_bus_op(OP_RD_BYTE, 16'h0300, 16'h0000);
    send_bus_op(OP_WR_PAGE, 16'h1FFF, 16'h00C3);
    send_bus_op(OP_RD_PAGE, 16'h1FFF, 16'h0000);
    send_bus_op(OP_RD_PAGE, 16'h20FF, 16'h0000);
  endtask

  // unmapped space ignores writes, unused opcodes do nothing
  task automatic test_unmapped_and_unused();
    send_bus_op(OP_WR_WORD, 16'h2000, 16'hFFFF);
    send_bus_op(OP_RD_WORD, 16'h2000, 16'h0000);
    send_bus_op(OP_RD_BYTE, 16'h3FFF, 16'h0000);
    send_bus_op(OP_WR_BYTE, 16'h8000, 16'h00FF);
    send_bus_op(OP_RD_BYTE, 16'h8000, 16'h0000);
    send_bus_op(OP_UNUSED_6, 16'h0000, 16'hFFFF);
    send_bus_op(OP_UNUSED_7, 16'hFFFF, 16'hFFFF);
    send_bus_op(OP_RD_BYTE, 16'h0000, 16'h0000);
  endtask

  // read address biased toward written ram, never touching unwritten bytes
  function automatic logic [ADDR_W-1:0] pick_read_address(logic [OP_W-1:0] op);
    logic [ADDR_W-1:0] addr;
    for (int tries = 0; tries < 16; tries++) begin
      if (written_idx_q.size() != 0 && $urandom_range(99) < 80) begin
        addr = 16'(written_idx_q[$urandom_range(written_idx_q.size() - 1)]
                   + RAM_DEPTH_DEF * $urandom_range(3));
      end else begin
        addr = 16'($urandom_range(16'hFFFF));
      end
      if (read_is_defined(op, addr)) return addr;
    end
    // fall back to unmapped space
    return 16'h4000 | 16'($urandom_range(16'h3FFF));
  endfunction

  // mixed traffic, mostly reads of what was written, with ram writes and unused opcodes
  task automatic test_random_traffic(int n_items);
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int                pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      data = 16'($urandom_range(16'hFFFF));
      if (pick < 30) begin
        // ram write
        case ($urandom_range(2))
          0:       op = OP_WR_BYTE;
          1:       op = OP_WR_WORD;
          default: op = OP_WR_PAGE;
        endcase
        addr = ($urandom_range(99) < 85) ? 16'($urandom_range(16'h1FFF))
                                         : 16'($urandom_range(16'hFFFF));
        send_bus_op(op, addr, data);
      end else if (pick < 80) begin
        // read of defined bytes
        case ($urandom_range(2))
          0:       op = OP_RD_BYTE;
          1:       op = OP_RD_WORD;
          default: op = OP_RD_PAGE;
        endcase
        send_bus_op(op, pick_read_address(op), data);
      end else if (pick < 90) begin
        // word write followed by its read back
        addr = 16'($urandom_range(16'h1FFF));
        if ($urandom_range(1) == 0) begin
          send_bus_op(OP_WR_WORD, addr, data);
          send_bus_op(OP_RD_WORD, addr, 16'($urandom_range(16'hFFFF)));
        end else begin
          send_bus_op(OP_WR_PAGE, addr, data);
          send_bus_op(OP_RD_PAGE, addr, 16'($urandom_range(16'hFFFF)));
        end
      end else if (pick < 95) begin
        op = ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        send_bus_op(op, 16'($urandom_range(16'hFFFF)), data);
      end else begin
        // write anywhere on the bus
        case ($urandom_range(2))
          0:       op = OP_WR_BYTE;
          1:       op = OP_WR_WORD;
          default: op = OP_WR_PAGE;
        endcase
        send_bus_op(op, 16'($urandom_range(16'hFFFF)), data);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_RD_BYTE;
    access_address_i = '0;
    write_data_i     = '0;
    mismatch_cnt     = 0;
    send_idle_pct    = 12;
    recv_stall_pct   = 65;
    foreach (shadow_written[i]) shadow_written[i] = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_byte_extremes();
    test_word_wrap();
    test_page_wrap();
    test_unmapped_and_unused();
    test_random_traffic(RANDOM_ITEMS);

    send_idle_pct  = 65;
    recv_stall_pct = 12;
    test_random_traffic(RANDOM_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_ITEMS);

    // drain the owed reads, then watch for stray results
    in_valid_i = 1'b0;
    while (pending_read_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_read_q.size() == 0) begin
      $display("console_cpu_bus_memory_map_unit: match");
    end else begin
      $display("console_cpu_bus_memory_map_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: console_cpu_bus_memory_map_unit.f
rtl/core/ccbmm_pkg.sv
rtl/core/ccbmm_ctrl.sv
rtl/core/ccbmm_datapath.sv
rtl/core/console_cpu_bus_memory_map_unit.sv
tb/sv/tb_console_cpu_bus_memory_map_unit.sv
